FILE: sv/stlpt_pkg.sv
// ----------------------------------------------------------------------------
// stlpt_pkg
// Shared types, codes and constants of the touch link and press tracker.
// ----------------------------------------------------------------------------
package stlpt_pkg;

  localparam int CNT_W = 16;                         // saturating counter width
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int XW = 12;
  localparam int YW = 15;
  localparam int CW = 15;                            // coordinate window bounds
  localparam int TW = 16;                            // timeout and count limits
  localparam int CFG_DW = 16;
  localparam int CFG_IW = 3;
  localparam int OUT_DW = 40;

  // Register indexes of the configuration port.
  localparam logic [CFG_IW-1:0] REG_COORD_MIN  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COORD_MAX  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BOARD_MODE = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LINK_TMO   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LONG_CNT   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_FORCE_TMO  = 3'd5;

  // Parser phases.
  localparam logic [2:0] PH_HEAD = 3'd0;
  localparam logic [2:0] PH_XH   = 3'd1;
  localparam logic [2:0] PH_XL   = 3'd2;
  localparam logic [2:0] PH_YH   = 3'd3;
  localparam logic [2:0] PH_YL   = 3'd4;

  // Panel bytes.
  localparam logic [7:0] BYTE_REPLY0 = 8'h0A;
  localparam logic [7:0] BYTE_REPLY1 = 8'h01;
  localparam logic [7:0] BYTE_REPLY2 = 8'h41;
  localparam logic [7:0] BYTE_DOWN   = 8'h81;
  localparam logic [7:0] BYTE_UP     = 8'h80;
  localparam logic [7:0] BYTE_XH_MAX = 8'h10;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_TEST   = 2'd1;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_REQUEST = 4'd1,
    EV_LINKED  = 4'd2,
    EV_READY   = 4'd3,
    EV_PRESS   = 4'd4,
    EV_LONG    = 4'd5,
    EV_RELEASE = 4'd6,
    EV_FORCED  = 4'd7,
    EV_DRAW    = 4'd8
  } ev_t;

  typedef struct packed {
    logic            linked;
    logic            request_sent;
    logic            ready_flag;
    logic [2:0]      parse_phase;
    logic [CNT_W-1:0] wait_count;
    logic            down_cmd;
    logic            up_cmd;
    logic            report_valid;
    logic [XW-1:0]   x_partial;
    logic [YW-1:0]   y_partial;
    logic [XW-1:0]   x_latched;
    logic [YW-1:0]   y_latched;
    logic            pressed;
    logic [CNT_W-1:0] hold_count;
    logic            long_done;
    logic            lamp;
  } st_t;

  typedef struct packed {
    logic [CW-1:0] coord_min;
    logic [CW-1:0] coord_max;
    logic [1:0]    board_mode;
    logic [TW-1:0] link_timeout;
    logic [TW-1:0] long_press;
    logic [TW-1:0] force_release;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Counter against limit, both zero-extended to a common width.
  function automatic logic reached(input logic [CNT_W-1:0] v, input logic [TW-1:0] lim);
    return 32'(v) >= 32'(lim);
  endfunction

endpackage

FILE: sv/stlpt_byte.sv
// ----------------------------------------------------------------------------
// stlpt_byte
// Next state for a received byte: handshake reply match and report parser.
// ----------------------------------------------------------------------------
module stlpt_byte (
  input  stlpt_pkg::st_t st,
  input  logic [7:0]     rx_byte,
  output stlpt_pkg::st_t st_next,
  output stlpt_pkg::ev_t ev
);
  import stlpt_pkg::*;

  logic [YW-1:0] y_full;

  assign y_full = st.y_partial + YW'(rx_byte[6:0]);

  always_comb begin
    st_next = st;
    ev = EV_NONE;
    if (!st.linked) begin
      if (st.request_sent) begin
        case (st.parse_phase)
          PH_HEAD: begin
            if (rx_byte == BYTE_REPLY0) st_next.parse_phase = PH_XH;
          end
          PH_XH: begin
            st_next.parse_phase = (rx_byte == BYTE_REPLY1) ? PH_XL : PH_HEAD;
          end
          PH_XL: begin
            st_next.parse_phase = PH_HEAD;
            if (rx_byte == BYTE_REPLY2) begin
              st_next.linked = 1'b1;
              st_next.lamp = 1'b1;
              st_next.wait_count = '0;
              st_next.ready_flag = 1'b0;
              ev = EV_LINKED;
            end
          end
          default: st_next.parse_phase = PH_HEAD;
        endcase
      end
    end else if (st.ready_flag) begin
      case (st.parse_phase)
        PH_HEAD: begin
          if (rx_byte == BYTE_DOWN) begin
            st_next.down_cmd = 1'b1;
            st_next.parse_phase = PH_XH;
          end else if (rx_byte == BYTE_UP) begin
            st_next.up_cmd = 1'b1;
            st_next.down_cmd = 1'b0;
            st_next.parse_phase = PH_XH;
          end
        end
        PH_XH: begin
          if (rx_byte > BYTE_XH_MAX) begin
            st_next.parse_phase = PH_HEAD;
          end else begin
            st_next.x_partial = {rx_byte[4:0], 7'd0};
            st_next.parse_phase = PH_XL;
          end
        end
        PH_XL: begin
          st_next.x_partial = st.x_partial + XW'(rx_byte[6:0]);
          st_next.parse_phase = PH_YH;
        end
        PH_YH: begin
          st_next.y_partial = {rx_byte, 7'd0};
          st_next.parse_phase = PH_YL;
        end
        PH_YL: begin
          st_next.y_partial = y_full;
          // A report still waiting for its tick keeps the latched position.
          if (!st.report_valid) begin
            st_next.report_valid = 1'b1;
            st_next.x_latched = st.x_partial;
            st_next.y_latched = y_full;
          end
          st_next.parse_phase = PH_HEAD;
        end
        default: st_next.parse_phase = PH_HEAD;
      endcase
    end
  end

endmodule

FILE: sv/stlpt_tick.sv
// ----------------------------------------------------------------------------
// stlpt_tick
// Next state for a tick: link timing, settle delay and touch events.
// ----------------------------------------------------------------------------
module stlpt_tick (
  input  stlpt_pkg::st_t  st,
  input  stlpt_pkg::cfg_t cfg,
  output stlpt_pkg::st_t  st_next,
  output stlpt_pkg::ev_t  ev
);
  import stlpt_pkg::*;

  logic             in_win;
  logic [CNT_W-1:0] wait_inc;
  logic [CNT_W-1:0] hold_inc;

  assign in_win = (CW'(st.x_latched) > cfg.coord_min) && (CW'(st.x_latched) < cfg.coord_max)
               && (st.y_latched > cfg.coord_min) && (st.y_latched < cfg.coord_max);
  assign wait_inc = sat_inc(st.wait_count);
  assign hold_inc = sat_inc(st.hold_count);

  always_comb begin
    st_next = st;
    ev = EV_NONE;
    if (!st.linked) begin
      if (!st.request_sent) begin
        st_next.request_sent = 1'b1;
        st_next.parse_phase = PH_HEAD;
        st_next.wait_count = '0;
        ev = EV_REQUEST;
      end else begin
        st_next.wait_count = wait_inc;
        if (reached(wait_inc, cfg.link_timeout)) st_next.request_sent = 1'b0;
      end
    end else if (!st.ready_flag) begin
      st_next.wait_count = wait_inc;
      if (reached(wait_inc, cfg.link_timeout)) begin
        st_next.wait_count = '0;
        st_next.ready_flag = 1'b1;
        st_next.lamp = 1'b0;
        ev = EV_READY;
      end
    end else if (!st.pressed) begin
      if (st.report_valid) begin
        if (st.down_cmd) begin
          if (in_win) begin
            st_next.lamp = 1'b1;
            st_next.pressed = 1'b1;
            st_next.hold_count = '0;
            st_next.long_done = 1'b0;
            ev = EV_PRESS;
          end
          st_next.down_cmd = 1'b0;
        end
        st_next.report_valid = 1'b0;
      end
    end else if (st.up_cmd) begin
      st_next.lamp = 1'b0;
      st_next.up_cmd = 1'b0;
      st_next.down_cmd = 1'b0;
      st_next.pressed = 1'b0;
      st_next.report_valid = 1'b0;
      ev = EV_RELEASE;
    end else if (cfg.board_mode == MODE_NORMAL || cfg.board_mode == MODE_TEST) begin
      if (st.report_valid) begin
        if (st.down_cmd) begin
          if (cfg.board_mode == MODE_NORMAL) begin
            if (!st.long_done && in_win) begin
              st_next.hold_count = hold_inc;
              if (reached(hold_inc, cfg.long_press)) begin
                st_next.long_done = 1'b1;
                ev = EV_LONG;
              end
            end
          end else if (in_win) begin
            ev = EV_DRAW;
          end
          st_next.down_cmd = 1'b0;
        end
        st_next.report_valid = 1'b0;
      end
    end else begin
      // Remaining modes count held ticks and release without touching the lamp.
      st_next.hold_count = hold_inc;
      if (reached(hold_inc, cfg.force_release)) begin
        st_next.pressed = 1'b0;
        st_next.report_valid = 1'b0;
        st_next.down_cmd = 1'b0;
        ev = EV_FORCED;
      end
    end
  end

endmodule

FILE: sv/serial_touch_link_and_press_tracker.sv
// ----------------------------------------------------------------------------
// serial_touch_link_and_press_tracker
// Touch panel link handshake, report parser and press event tracker.
// ----------------------------------------------------------------------------
// A result is on m_tdata in the cycle after its request is accepted.
// Throughput: one request per cycle; the tracker state and the result register
// are both written at the accepting edge, so s_tready only waits on m_tready.
// Reset (rst, synchronous): clears all tracker state and the result valid,
// and loads the configuration registers with their default values.
module serial_touch_link_and_press_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  input  logic                            s_tuser,   // func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // event_res[3:0], pos_x[15:4], pos_y[30:16], led_on[31], link_up[32],
  // panel_ready[33], zero fill above
  output logic [stlpt_pkg::OUT_DW-1:0]    m_tdata,
  input  logic                            cfg_we,
  input  logic [stlpt_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [stlpt_pkg::CFG_DW-1:0]    cfg_wdata
);
  import stlpt_pkg::*;

  st_t   st;
  st_t   st_next;
  st_t   st_byte;
  st_t   st_tick;
  ev_t   ev_byte;
  ev_t   ev_tick;
  ev_t   ev;
  cfg_t  cfg;
  logic  accept;
  logic  show_pos;
  logic [OUT_DW-1:0] result;

  stlpt_byte u_byte (
    .st      (st),
    .rx_byte (s_tdata),
    .st_next (st_byte),
    .ev      (ev_byte)
  );

  stlpt_tick u_tick (
    .st      (st),
    .cfg     (cfg),
    .st_next (st_tick),
    .ev      (ev_tick)
  );

  assign st_next  = s_tuser ? st_tick : st_byte;
  assign ev       = s_tuser ? ev_tick : ev_byte;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign show_pos = (ev == EV_PRESS) || (ev == EV_LONG) || (ev == EV_DRAW);

  assign result = {6'd0, st_next.ready_flag, st_next.linked, st_next.lamp,
                   show_pos ? st_next.y_latched : YW'(0),
                   show_pos ? st_next.x_latched : XW'(0),
                   ev};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coord_min     <= CW'(100);
      cfg.coord_max     <= CW'(4000);
      cfg.board_mode    <= MODE_NORMAL;
      cfg.link_timeout  <= TW'(500);
      cfg.long_press    <= TW'(100);
      cfg.force_release <= TW'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COORD_MIN:  cfg.coord_min     <= cfg_wdata[CW-1:0];
        REG_COORD_MAX:  cfg.coord_max     <= cfg_wdata[CW-1:0];
        REG_BOARD_MODE: cfg.board_mode    <= cfg_wdata[1:0];
        REG_LINK_TMO:   cfg.link_timeout  <= cfg_wdata[TW-1:0];
        REG_LONG_CNT:   cfg.long_press    <= cfg_wdata[TW-1:0];
        REG_FORCE_TMO:  cfg.force_release <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result;
    end
  end

  a_ready_needs_link: assert property (@(posedge clk) disable iff (rst)
    st.ready_flag |-> st.linked)
    else $error("panel ready without link");

  a_press_needs_ready: assert property (@(posedge clk) disable iff (rst)
    st.pressed |-> st.ready_flag)
    else $error("press tracked before panel ready");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted request produced no result");

  a_press_lights_lamp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3:0] == EV_PRESS) |-> m_tdata[31])
    else $error("press event with lamp off");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.parse_phase <= PH_YL)
    else $error("parser phase out of range");

endmodule

FILE: tb/sv/touch_event_checker.sv
// ----------------------------------------------------------------------------
// touch_event_checker
// Watches both streams of the touch link and press tracker, predicts the
// result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module touch_event_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [stlpt_pkg::OUT_DW-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [stlpt_pkg::CFG_IW-1:0] cfg_index,
  input  logic [stlpt_pkg::CFG_DW-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import stlpt_pkg::*;

  typedef struct packed {
    logic [5:0]    pad;
    logic          rdy;
    logic          link;
    logic          led;
    logic [YW-1:0] y;
    logic [XW-1:0] x;
    ev_t           ev;
  } touch_result_t;

  // Configuration copy.
  logic [CW-1:0] win_lo, win_hi;
  logic [1:0]    mode;
  logic [TW-1:0] link_tmo, long_limit, release_limit;

  // Tracker state copy.
  logic             link_ok, req_pending, panel_rdy;
  logic [2:0]       phase;
  logic [CNT_W-1:0] wait_ticks, hold_ticks;
  logic             down_seen, up_seen, report_held;
  logic [XW-1:0]    x_acc, x_pos;
  logic [YW-1:0]    y_acc, y_pos;
  logic             touching, long_sent, lamp_on;

  touch_result_t expected_results[$];

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic in_window();
    return CW'(x_pos) > win_lo && CW'(x_pos) < win_hi && y_pos > win_lo && y_pos < win_hi;
  endfunction

  function automatic touch_result_t advance_tracker(input logic tick, input logic [7:0] b);
    ev_t ev;
    touch_result_t r;
    ev = EV_NONE;
    if (!tick) begin
      if (!link_ok) begin
        // The reply parser reuses the first report phases as its own steps.
        if (req_pending) begin
          case (phase)
            PH_HEAD: if (b == BYTE_REPLY0) phase = PH_XH;
            PH_XH:   phase = (b == BYTE_REPLY1) ? PH_XL : PH_HEAD;
            PH_XL: begin
              phase = PH_HEAD;
              if (b == BYTE_REPLY2) begin
                link_ok = 1'b1;
                lamp_on = 1'b1;
                wait_ticks = '0;
                panel_rdy = 1'b0;
                ev = EV_LINKED;
              end
            end
            default: phase = PH_HEAD;
          endcase
        end
      end else if (panel_rdy) begin
        case (phase)
          PH_HEAD: begin
            if (b == BYTE_DOWN) begin
              down_seen = 1'b1;
              phase = PH_XH;
            end else if (b == BYTE_UP) begin
              up_seen = 1'b1;
              down_seen = 1'b0;
              phase = PH_XH;
            end
          end
          PH_XH: begin
            if (b > BYTE_XH_MAX) begin
              phase = PH_HEAD;
            end else begin
              x_acc = XW'(b) << 7;
              phase = PH_XL;
            end
          end
          PH_XL: begin
            x_acc = x_acc + XW'(b[6:0]);
            phase = PH_YH;
          end
          PH_YH: begin
            y_acc = YW'(b) << 7;
            phase = PH_YL;
          end
          PH_YL: begin
            y_acc = y_acc + YW'(b[6:0]);
            if (!report_held) begin
              report_held = 1'b1;
              x_pos = x_acc;
              y_pos = y_acc;
            end
            phase = PH_HEAD;
          end
          default: phase = PH_HEAD;
        endcase
      end
    end else if (!link_ok) begin
      if (!req_pending) begin
        req_pending = 1'b1;
        phase = PH_HEAD;
        wait_ticks = '0;
        ev = EV_REQUEST;
      end else begin
        wait_ticks = bump(wait_ticks);
        if (wait_ticks >= link_tmo) req_pending = 1'b0;
      end
    end else if (!panel_rdy) begin
      wait_ticks = bump(wait_ticks);
      if (wait_ticks >= link_tmo) begin
        wait_ticks = '0;
        panel_rdy = 1'b1;
        lamp_on = 1'b0;
        ev = EV_READY;
      end
    end else if (!touching) begin
      if (report_held) begin
        if (down_seen) begin
          if (in_window()) begin
            lamp_on = 1'b1;
            touching = 1'b1;
            hold_ticks = '0;
            long_sent = 1'b0;
            ev = EV_PRESS;
          end
          down_seen = 1'b0;
        end
        report_held = 1'b0;
      end
    end else if (up_seen) begin
      lamp_on = 1'b0;
      up_seen = 1'b0;
      down_seen = 1'b0;
      touching = 1'b0;
      report_held = 1'b0;
      ev = EV_RELEASE;
    end else if (mode == MODE_NORMAL || mode == MODE_TEST) begin
      if (report_held) begin
        if (down_seen) begin
          if (mode == MODE_NORMAL) begin
            if (!long_sent && in_window()) begin
              hold_ticks = bump(hold_ticks);
              if (hold_ticks >= long_limit) begin
                long_sent = 1'b1;
                ev = EV_LONG;
              end
            end
          end else if (in_window()) begin
            ev = EV_DRAW;
          end
          down_seen = 1'b0;
        end
        report_held = 1'b0;
      end
    end else begin
      // Any other mode holds the press for a while and then drops it; the lamp stays.
      hold_ticks = bump(hold_ticks);
      if (hold_ticks >= release_limit) begin
        touching = 1'b0;
        report_held = 1'b0;
        down_seen = 1'b0;
        ev = EV_FORCED;
      end
    end
    r = '0;
    r.ev = ev;
    if (ev == EV_PRESS || ev == EV_LONG || ev == EV_DRAW) begin
      r.x = x_pos;
      r.y = y_pos;
    end
    r.led = lamp_on;
    r.link = link_ok;
    r.rdy = panel_rdy;
    return r;
  endfunction

  function automatic void flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, what);
  endfunction

  always @(posedge clk) begin
    touch_result_t got, want;
    if (rst) begin
      win_lo = 15'd100;
      win_hi = 15'd4000;
      mode = MODE_NORMAL;
      link_tmo = 16'd500;
      long_limit = 16'd100;
      release_limit = 16'd1000;
      {link_ok, req_pending, panel_rdy} = '0;
      phase = PH_HEAD;
      wait_ticks = '0;
      hold_ticks = '0;
      {down_seen, up_seen, report_held} = '0;
      x_acc = '0;
      y_acc = '0;
      x_pos = '0;
      y_pos = '0;
      {touching, long_sent, lamp_on} = '0;
      expected_results.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COORD_MIN:  win_lo = cfg_wdata[CW-1:0];
          REG_COORD_MAX:  win_hi = cfg_wdata[CW-1:0];
          REG_BOARD_MODE: mode = cfg_wdata[1:0];
          REG_LINK_TMO:   link_tmo = cfg_wdata[TW-1:0];
          REG_LONG_CNT:   long_limit = cfg_wdata[TW-1:0];
          REG_FORCE_TMO:  release_limit = cfg_wdata[TW-1:0];
          default: ;
        endcase
      end
      // A result never leaves on the edge that accepts its own request.
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          flag($sformatf("result %h with nothing outstanding", m_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.ev !== want.ev || got.x !== want.x || got.y !== want.y ||
              got.led !== want.led || got.link !== want.link || got.rdy !== want.rdy)
            flag({$sformatf("exp ev=%0d x=%0d y=%0d led=%b link=%b rdy=%b, ",
                            want.ev, want.x, want.y, want.led, want.link, want.rdy),
                  $sformatf("got ev=%0d x=%0d y=%0d led=%b link=%b rdy=%b",
                            got.ev, got.x, got.y, got.led, got.link, got.rdy)});
        end
      end
      if (s_tvalid && s_tready) expected_results.push_back(advance_tracker(s_tuser, s_tdata));
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: tb/sv/tb_serial_touch_link_and_press_tracker.sv
// ----------------------------------------------------------------------------
// tb_serial_touch_link_and_press_tracker
// Drives the handshake, report bytes and ticks into the tracker under
// several register settings and idling patterns; the checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_serial_touch_link_and_press_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import stlpt_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEMS_PER_PHASE = 220;
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic [1:0] MODE_FORCED = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_DW-1:0]   m_tdata;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  int mismatches, outstanding;
  int cycles = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  cfg_t phase_cfg [8];

  serial_touch_link_and_press_tracker dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  touch_event_checker event_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Holds the request until it is taken, then maybe leaves the bus idle.
  // The caller issues the next request in the same step, so tvalid stays up.
  task automatic push_item(input logic tick, input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= tick;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_report(input logic [7:0] hd, xh, xl, yh, yl, input int n);
    logic [7:0] bytes [5];
    bytes = '{hd, xh, xl, yh, yl};
    for (int i = 0; i < n; i++) push_item(FUNC_BYTE, bytes[i]);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input cfg_t c);
    write_reg(REG_COORD_MIN, CFG_DW'(c.coord_min));
    write_reg(REG_COORD_MAX, CFG_DW'(c.coord_max));
    write_reg(REG_BOARD_MODE, CFG_DW'(c.board_mode));
    write_reg(REG_LINK_TMO, c.link_timeout);
    write_reg(REG_LONG_CNT, c.long_press);
    write_reg(REG_FORCE_TMO, c.force_release);
    cfg_we <= 1'b0;
  endtask

  // The extra edge lets the checker's count take in the last request.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed reports followed by ticks, with some tick runs,
  // cut-off reports and stray bytes.
  task automatic random_chunk();
    int r, ticks;
    logic [7:0] hd, xh, yh;
    r = $urandom_range(99);
    ticks = 0;
    hd = ($urandom_range(99) < 75) ? BYTE_DOWN : BYTE_UP;
    xh = ($urandom_range(99) < 90) ? 8'($urandom_range(16)) : 8'($urandom_range(255, 17));
    yh = ($urandom_range(99) < 80) ? 8'($urandom_range(40)) : 8'($urandom);
    if (r < 55) begin
      send_report(hd, xh, 8'($urandom), yh, 8'($urandom), 5);
      ticks = $urandom_range(3);
    end else if (r < 80) begin
      ticks = $urandom_range(6, 1);
    end else if (r < 92) begin
      send_report(hd, xh, 8'($urandom), yh, 8'($urandom), $urandom_range(4, 1));
      ticks = $urandom_range(1);
    end else begin
      push_item(FUNC_BYTE, 8'($urandom));
      ticks = $urandom_range(1);
    end
    repeat (ticks) push_item(FUNC_TICK, 8'($urandom));
  endtask

  initial begin
    int target;
    phase_cfg[0] = '{15'd100, 15'd4000, MODE_NORMAL, 16'd3, 16'd2, 16'd1000};
    phase_cfg[1] = '{15'd0, 15'd32767, MODE_TEST, 16'd65535, 16'd1, 16'd1};
    phase_cfg[2] = '{15'd100, 15'd4000, MODE_FORCED, 16'd1, 16'd100, 16'd3};
    phase_cfg[3] = '{15'd50, 15'd2100, MODE_SPARE, 16'd7, 16'd4, 16'd0};
    phase_cfg[4] = '{15'd32767, 15'd0, MODE_NORMAL, 16'd0, 16'd0, 16'd65535};
    phase_cfg[5] = '{15'd0, 15'd32767, MODE_NORMAL, 16'd10, 16'd65535, 16'd5};
    phase_cfg[6] = '{15'd200, 15'd1500, MODE_FORCED, 16'd2, 16'd3, 16'd65535};
    phase_cfg[7] = '{15'd1, 15'd2176, MODE_TEST, 16'd4, 16'd5, 16'd8};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the whole link handshake, then a few edge-case reports.
    write_settings('{15'd100, 15'd20000, MODE_NORMAL, 16'd2, 16'd2, 16'd2});
    push_item(FUNC_BYTE, BYTE_REPLY0);            // dropped, no connect request yet
    push_item(FUNC_TICK, 8'h00);                  // connect request
    push_item(FUNC_TICK, 8'hFF);
    push_item(FUNC_TICK, 8'h00);                  // wait runs out, request withdrawn
    push_item(FUNC_TICK, 8'h00);                  // request again
    send_report(BYTE_REPLY0, BYTE_REPLY1, 8'h42, 8'h00, 8'h00, 3);
    send_report(BYTE_REPLY0, BYTE_REPLY1, BYTE_REPLY2, 8'h00, 8'h00, 3);
    push_item(FUNC_BYTE, BYTE_DOWN);              // dropped while settling
    push_item(FUNC_TICK, 8'h00);
    push_item(FUNC_TICK, 8'h00);                  // ready
    send_report(BYTE_DOWN, BYTE_XH_MAX, 8'h7F, 8'h7F, 8'h7F, 5);
    push_item(FUNC_TICK, 8'h00);                  // press at the largest X
    send_report(BYTE_UP, 8'h11, 8'h00, 8'h00, 8'h00, 2);
    push_item(FUNC_TICK, 8'h00);                  // up header alone releases
    send_report(BYTE_DOWN, 8'h00, 8'hFF, 8'hFF, 8'hFF, 5);
    push_item(FUNC_TICK, 8'h00);                  // Y outside the window

    for (int p = 0; p < 8; p++) begin
      settle();
      write_settings(phase_cfg[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_chunk();
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/stlpt_pkg.sv
sv/stlpt_byte.sv
sv/stlpt_tick.sv
sv/serial_touch_link_and_press_tracker.sv
tb/sv/touch_event_checker.sv
tb/sv/tb_serial_touch_link_and_press_tracker.sv
